@@ hw/rtl/pcdl_pkg.sv @@
package pcdl_pkg;

    localparam int PIN_DIGITS_DEF    = 4;
    localparam int BUFFER_DIGITS_DEF = 16;
    localparam int MAX_TRIES_DEF     = 3;

    localparam int NUM_USERS    = 3;
    localparam int PIN_TABLE_W  = 48;
    localparam int CARD_W       = 32;
    localparam int TICK_W       = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 48;
    localparam int COUNT_OUT_W  = 5;

    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_CARD = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [3:0] KEY_SUBMIT = 4'd15;

    localparam logic [3:0] ST_NONE     = 4'd0;
    localparam logic [3:0] ST_DIGIT    = 4'd1;
    localparam logic [3:0] ST_WRONG    = 4'd2;
    localparam logic [3:0] ST_SCAN     = 4'd3;
    localparam logic [3:0] ST_TIMEOUT  = 4'd4;
    localparam logic [3:0] ST_BADCARD  = 4'd5;
    localparam logic [3:0] ST_GRANTED  = 4'd6;
    localparam logic [3:0] ST_LOCKED   = 4'd7;
    localparam logic [3:0] ST_RELEASED = 4'd8;
    localparam logic [3:0] ST_CLOSED   = 4'd9;
    localparam logic [3:0] ST_IGNORED  = 4'd10;

    localparam logic [1:0] MODE_PIN  = 2'd0;
    localparam logic [1:0] MODE_CARD = 2'd1;
    localparam logic [1:0] MODE_OPEN = 2'd2;
    localparam logic [1:0] MODE_LOCK = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_PIN_TABLE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARD_USER0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARD_USER1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARD_USER2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARD_WAIT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPEN       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECHECK    = 3'd6;

    localparam logic [TICK_W-1:0] CARD_WAIT_RST = 16'd200;
    localparam logic [TICK_W-1:0] OPEN_RST      = 16'd40;
    localparam logic [TICK_W-1:0] RECHECK_RST   = 16'd100;

    typedef struct packed {
        logic [1:0]        operation;
        logic [3:0]        key_code;
        logic [CARD_W-1:0] card_uid;
        logic              motion;
    } t_in;

    typedef struct packed {
        logic [3:0]             status;
        logic [1:0]             user_index;
        logic [COUNT_OUT_W-1:0] digit_count;
        logic                   door_open;
        logic                   green_light;
        logic                   red_light;
        logic                   alarm;
    } t_out;

    typedef struct packed {
        logic [PIN_TABLE_W-1:0]             pin_table;
        logic [NUM_USERS-1:0][CARD_W-1:0]   card_user;
        logic [TICK_W-1:0]                  card_wait_ticks;
        logic [TICK_W-1:0]                  open_ticks;
        logic [TICK_W-1:0]                  recheck_ticks;
    } t_cfg;

    typedef struct packed {
        logic       hit;
        logic [1:0] user;
    } t_match;

endpackage

@@ hw/rtl/pin_and_card_door_lock.sv @@
// Path: an accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle; the input register and the result
// register each advance whenever the stage after them is free.
// Reset (synchronous, active low): pin entry mode, no digits, lights and alarm
// off, configuration back to its defaults; no result pending.
module pin_and_card_door_lock
    import pcdl_pkg::*;
#(
    parameter int PIN_DIGITS    = PIN_DIGITS_DEF,
    parameter int BUFFER_DIGITS = BUFFER_DIGITS_DEF,
    parameter int MAX_TRIES     = MAX_TRIES_DEF
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in                    i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out                   o_out_data,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;
    logic w_step;
    t_cfg w_cfg;
    t_out w_result;

    pcdl_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pcdl_ctrl #(
        .PIN_DIGITS    (PIN_DIGITS),
        .BUFFER_DIGITS (BUFFER_DIGITS),
        .MAX_TRIES     (MAX_TRIES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_green_tracks_door: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.door_open == r_out.green_light))
        else $error("green light differs from door state");

    a_red_with_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.red_light == r_out.alarm))
        else $error("red light and alarm disagree");

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("processed request produced no result");

    a_open_not_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.door_open |-> !r_out.red_light)
        else $error("door open during lockout");

endmodule

@@ hw/rtl/pcdl_cfg_regs.sv @@
module pcdl_cfg_regs
    import pcdl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pin_table       <= '0;
            r_cfg.card_user       <= '0;
            r_cfg.card_wait_ticks <= CARD_WAIT_RST;
            r_cfg.open_ticks      <= OPEN_RST;
            r_cfg.recheck_ticks   <= RECHECK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PIN_TABLE:  r_cfg.pin_table       <= i_cfg_data[PIN_TABLE_W-1:0];
                CFG_CARD_USER0: r_cfg.card_user[0]    <= i_cfg_data[CARD_W-1:0];
                CFG_CARD_USER1: r_cfg.card_user[1]    <= i_cfg_data[CARD_W-1:0];
                CFG_CARD_USER2: r_cfg.card_user[2]    <= i_cfg_data[CARD_W-1:0];
                CFG_CARD_WAIT:  r_cfg.card_wait_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_OPEN:       r_cfg.open_ticks      <= i_cfg_data[TICK_W-1:0];
                CFG_RECHECK:    r_cfg.recheck_ticks   <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/pcdl_pin_match.sv @@
module pcdl_pin_match
    import pcdl_pkg::*;
#(
    parameter int PIN_DIGITS    = PIN_DIGITS_DEF,
    parameter int BUFFER_DIGITS = BUFFER_DIGITS_DEF,
    localparam int CNT_W        = $clog2(BUFFER_DIGITS + 1),
    localparam int TBL_W        = NUM_USERS * 4 * PIN_DIGITS
)
(
    input  logic [CNT_W-1:0]           i_digits,
    input  logic [PIN_DIGITS-1:0][3:0] i_buffer,
    input  logic [PIN_TABLE_W-1:0]     i_pin_table,
    output t_match                     o_match
);

    logic [TBL_W+PIN_TABLE_W-1:0] w_ext;
    logic [TBL_W-1:0]             w_tbl;
    logic                         w_len_ok;

    assign w_ext    = {{TBL_W{1'b0}}, i_pin_table};
    assign w_tbl    = w_ext[TBL_W-1:0];
    assign w_len_ok = (32'(i_digits) == PIN_DIGITS);

    always_comb begin
        logic ok;
        o_match = '0;
        for (int u = 0; u < NUM_USERS; u++) begin
            ok = w_len_ok;
            for (int i = 0; i < PIN_DIGITS; i++) begin
                if (i_buffer[i] != w_tbl[(u * PIN_DIGITS + i) * 4 +: 4]) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                o_match.hit  = 1'b1;
                o_match.user = 2'(u);
            end
        end
    end

endmodule

@@ hw/rtl/pcdl_ctrl.sv @@
module pcdl_ctrl
    import pcdl_pkg::*;
#(
    parameter int PIN_DIGITS    = PIN_DIGITS_DEF,
    parameter int BUFFER_DIGITS = BUFFER_DIGITS_DEF,
    parameter int MAX_TRIES     = MAX_TRIES_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output t_out o_result
);

    localparam int CNT_W = $clog2(BUFFER_DIGITS + 1);
    localparam int TRY_W = $clog2(MAX_TRIES + 1);
    localparam int IDX_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;

    logic [1:0]        r_mode,   n_mode;
    logic [CNT_W-1:0]  r_digits, n_digits;
    logic [TRY_W-1:0]  r_tries,  n_tries;
    logic [1:0]        r_user,   n_user;
    logic [TICK_W-1:0] r_timer,  n_timer;
    logic              r_green,  n_green;
    logic              r_red,    n_red;
    logic              r_alarm,  n_alarm;

    logic [PIN_DIGITS-1:0][3:0] r_buffer;
    logic                       w_buf_we;
    logic [3:0]                 w_status;
    logic [TRY_W-1:0]           w_tries_inc;
    logic [CARD_W-1:0]          w_card;
    t_match                     w_match;

    pcdl_pin_match #(
        .PIN_DIGITS    (PIN_DIGITS),
        .BUFFER_DIGITS (BUFFER_DIGITS)
    ) u_pin_match (
        .i_digits    (r_digits),
        .i_buffer    (r_buffer),
        .i_pin_table (i_cfg.pin_table),
        .o_match     (w_match)
    );

    assign w_tries_inc = r_tries + 1'b1;
    assign w_card      = (r_user < 2'(NUM_USERS)) ? i_cfg.card_user[r_user]
                                                  : i_cfg.card_user[0];

    always_comb begin
        n_mode   = r_mode;
        n_digits = r_digits;
        n_tries  = r_tries;
        n_user   = r_user;
        n_timer  = r_timer;
        n_green  = r_green;
        n_red    = r_red;
        n_alarm  = r_alarm;
        w_buf_we = 1'b0;
        w_status = ST_NONE;
        case (i_item.operation)
            OP_KEY: begin
                if (r_mode != MODE_PIN) begin
                    w_status = ST_IGNORED;
                end else if (i_item.key_code != KEY_SUBMIT) begin
                    if (32'(r_digits) >= BUFFER_DIGITS) begin
                        w_status = ST_IGNORED;
                    end else begin
                        w_buf_we = (32'(r_digits) < PIN_DIGITS);
                        n_digits = r_digits + 1'b1;
                        w_status = ST_DIGIT;
                    end
                end else begin
                    n_digits = '0;
                    if (w_match.hit) begin
                        n_user   = w_match.user;
                        n_mode   = MODE_CARD;
                        n_timer  = i_cfg.card_wait_ticks;
                        w_status = ST_SCAN;
                    end else if (32'(w_tries_inc) >= MAX_TRIES) begin
                        n_tries  = '0;
                        n_mode   = MODE_LOCK;
                        n_red    = 1'b1;
                        n_alarm  = 1'b1;
                        w_status = ST_LOCKED;
                    end else begin
                        n_tries  = w_tries_inc;
                        w_status = ST_WRONG;
                    end
                end
            end
            OP_CARD: begin
                if (r_mode == MODE_CARD) begin
                    n_tries  = '0;
                    n_digits = '0;
                    if (i_item.card_uid == w_card) begin
                        n_mode   = MODE_OPEN;
                        n_timer  = i_cfg.open_ticks;
                        n_green  = 1'b1;
                        w_status = ST_GRANTED;
                    end else begin
                        n_mode   = MODE_PIN;
                        w_status = ST_BADCARD;
                    end
                end else if (r_mode == MODE_LOCK) begin
                    n_mode   = MODE_PIN;
                    n_green  = 1'b0;
                    n_red    = 1'b0;
                    n_alarm  = 1'b0;
                    n_tries  = '0;
                    n_digits = '0;
                    w_status = ST_RELEASED;
                end else begin
                    w_status = ST_IGNORED;
                end
            end
            OP_TICK: begin
                if (r_mode == MODE_CARD) begin
                    if (r_timer > 16'd1) begin
                        n_timer = r_timer - 1'b1;
                    end else begin
                        n_timer  = '0;
                        n_tries  = '0;
                        n_digits = '0;
                        n_mode   = MODE_PIN;
                        w_status = ST_TIMEOUT;
                    end
                end else if (r_mode == MODE_OPEN) begin
                    if (r_timer > 16'd1) begin
                        n_timer = r_timer - 1'b1;
                    end else if (i_item.motion) begin
                        n_timer = i_cfg.recheck_ticks;
                    end else begin
                        n_timer  = '0;
                        n_green  = 1'b0;
                        n_red    = 1'b0;
                        n_alarm  = 1'b0;
                        n_mode   = MODE_PIN;
                        w_status = ST_CLOSED;
                    end
                end
            end
            default: begin
                w_status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PIN;
            r_digits <= '0;
            r_tries  <= '0;
            r_user   <= '0;
            r_timer  <= '0;
            r_green  <= 1'b0;
            r_red    <= 1'b0;
            r_alarm  <= 1'b0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_digits <= n_digits;
            r_tries  <= n_tries;
            r_user   <= n_user;
            r_timer  <= n_timer;
            r_green  <= n_green;
            r_red    <= n_red;
            r_alarm  <= n_alarm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && w_buf_we) begin
            r_buffer[r_digits[IDX_W-1:0]] <= i_item.key_code;
        end
    end

    always_comb begin
        o_result             = '0;
        o_result.status      = w_status;
        o_result.user_index  = n_user;
        o_result.digit_count = COUNT_OUT_W'(n_digits);
        o_result.door_open   = (n_mode == MODE_OPEN);
        o_result.green_light = n_green;
        o_result.red_light   = n_red;
        o_result.alarm       = n_alarm;
    end

endmodule
